### src/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg: shared types and constants of the Huffman stream decoder
// Holds the phase codes, the node entry layout and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none
package hsd_pkg;
	localparam logic [1:0] PH_TRIE = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DEC  = 2'd2;
	localparam int NODE_W = 10;
	localparam int LEAF_BIT = 9;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
		logic       status;
	} result_t;
endpackage
`default_nettype wire

### src/hsd_if.sv
// ----------------------------------------------------------------------------
// hsd_byte_if / hsd_res_if: ready-valid channels of the decoder
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
`default_nettype none
interface hsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface hsd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last;
	logic       status;
	modport source (output valid, output symbol, output last, output status, input ready);
	modport sink   (input valid, input symbol, input last, input status, output ready);
endinterface
`default_nettype wire

### src/hsd_ram.sv
// ----------------------------------------------------------------------------
// hsd_ram: generic single-port-write, single-port-read RAM
// Registered read data; contents undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module hsd_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### src/hsd_front.sv
// ----------------------------------------------------------------------------
// hsd_front: input stage of the decoder
// Accepts byte beats and holds them in a short queue for the bit engine.
// ----------------------------------------------------------------------------
`default_nettype none
module hsd_front #(
	parameter int DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	hsd_byte_if.sink        in_ch,
	output logic            avail,
	output logic [7:0]      head,
	input  wire logic       pop
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	logic [7:0]  buf_q [DEPTH];
	logic [AW-1:0] rd_q, wr_q;
	logic [AW:0] cnt_q;
	logic push;

	assign in_ch.ready = (cnt_q != (AW+1)'(DEPTH));
	assign push  = in_ch.valid && in_ch.ready;
	assign avail = (cnt_q != '0);
	assign head  = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_ch.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> avail)
		else $error("pop from empty queue");
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue overfilled");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
endmodule
`default_nettype wire

### src/hsd_back.sv
// ----------------------------------------------------------------------------
// hsd_back: bit engine of the decoder
// Builds the trie, reads the count and walks the code words, one bit a step.
// ----------------------------------------------------------------------------
`default_nettype none
module hsd_back #(
	parameter int MAX_NODES   = 512,
	parameter int STACK_DEPTH = 256
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   avail,
	input  wire logic [7:0] head,
	output logic        pop,
	hsd_res_if.source   out_ch
);
	import hsd_pkg::*;
	localparam int NA = $clog2(MAX_NODES);
	localparam int SA = $clog2(STACK_DEPTH);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int SPW = $clog2(STACK_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_BIT  = 3'd1;
	localparam logic [2:0] S_RD1  = 3'd2;  // walk: entry of current node
	localparam logic [2:0] S_RD2  = 3'd3;  // walk: entry of next node
	localparam logic [2:0] S_POPW = 3'd4;  // stack read returning
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]  st_q;
	logic [1:0]  phase_q;
	logic [7:0]  byte_q;
	logic [3:0]  bitn_q;   // bits left in byte
	logic [NCW-1:0] ncnt_q;
	logic [SPW-1:0] sp_q;
	logic [7:0]  cshift_q;
	logic [3:0]  cleft_q;
	logic [31:0] rem_q;
	logic [2:0]  lbl_q;
	logic [8:0]  walk_q, next_q;
	logic        done_q;
	result_t     pend_q;   // beat waiting for the output register
	result_t     res_q;
	logic        rv_q;

	logic           nwe;
	logic [NA-1:0]  nwa, nra;
	logic [NODE_W-1:0] nwd, nrd;
	logic           swe;
	logic [SA-1:0]  swa, sra;
	logic [8:0]     swd, srd;

	hsd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_nodes (
		.clk, .we(nwe), .waddr(nwa), .wdata(nwd), .raddr(nra), .rdata(nrd));
	hsd_ram #(.WIDTH(9), .DEPTH(STACK_DEPTH)) u_stack (
		.clk, .we(swe), .waddr(swa), .wdata(swd), .raddr(sra), .rdata(srd));

	logic bit_w;
	logic [7:0] csh_n;
	assign bit_w = byte_q[7];
	assign csh_n = {cshift_q[6:0], bit_w};

	assign out_ch.valid  = rv_q;
	assign out_ch.symbol = res_q.symbol;
	assign out_ch.last   = res_q.last;
	assign out_ch.status = res_q.status;
	assign pop = (st_q == S_LOAD) && avail;

	logic leaf_now, nc_full;
	assign leaf_now = (phase_q != PH_LEN) && (phase_q != PH_DEC) && (cleft_q != 0)
		&& (cleft_q == 4'd1);
	assign nc_full = (ncnt_q >= NCW'(MAX_NODES));

	always_comb begin
		nwe = 1'b0; nwa = ncnt_q[NA-1:0]; nwd = '0;
		swe = 1'b0; swa = sp_q[SA-1:0]; swd = 9'(ncnt_q);
		nra = walk_q[NA-1:0]; sra = SA'(sp_q - 1'b1);
		// fetch the next node while the current entry is on the read port
		if (st_q == S_RD1) nra = bit_w ? nrd[NA-1:0] : NA'(walk_q + 9'd1);
		if (st_q == S_BIT && phase_q != PH_LEN && phase_q != PH_DEC) begin
			if (cleft_q != 0) begin
				if (cleft_q == 4'd1 && !nc_full) begin
					nwe = 1'b1; nwd = {1'b1, 1'b0, csh_n};
				end
			end else if (!nc_full && !bit_w && sp_q < SPW'(STACK_DEPTH)) begin
				nwe = 1'b1; nwd = '0; swe = 1'b1;
			end
		end
		if (st_q == S_POPW && (srd < 9'(MAX_NODES) || MAX_NODES == 512)) begin
			nwe = 1'b1; nwa = srd[NA-1:0]; nwd = NODE_W'(ncnt_q[8:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_LOAD && avail) byte_q <= head;
		else if ((st_q == S_BIT && phase_q != PH_DEC) || st_q == S_RD2)
			byte_q <= {byte_q[6:0], 1'b0};
	end

	// load bytes, advance one bit, hand out result beats; drop the rest of the byte when a stream ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD; phase_q <= PH_TRIE; bitn_q <= '0; ncnt_q <= '0; sp_q <= '0;
			cshift_q <= '0; cleft_q <= '0; rem_q <= '0; lbl_q <= 3'd4; walk_q <= '0;
			next_q <= '0; done_q <= 1'b0; rv_q <= 1'b0; res_q <= '0; pend_q <= '0;
		end else begin
			if (rv_q && out_ch.ready && st_q != S_OUT) rv_q <= 1'b0;
			case (st_q)
				S_LOAD: if (avail) begin bitn_q <= 4'd8; st_q <= S_BIT; end
				S_BIT: begin
					logic fin, err;
					fin = 1'b0; err = 1'b0;
					if (phase_q == PH_LEN) begin
						if (cleft_q == 4'd1) begin
							rem_q <= {rem_q[23:0], csh_n}; cshift_q <= '0;
							lbl_q <= lbl_q - 1'b1; cleft_q <= 4'd8;
							if (lbl_q == 3'd1) begin
								if ({rem_q[23:0], csh_n} == 32'd0) fin = 1'b1;
								else begin phase_q <= PH_DEC; walk_q <= '0; end
							end
						end else begin
							cshift_q <= csh_n; cleft_q <= cleft_q - 1'b1;
						end
					end else if (phase_q == PH_DEC) begin
						st_q <= S_RD1;
					end else if (cleft_q != 0) begin
						if (leaf_now) begin
							ncnt_q <= ncnt_q + 1'b1; cshift_q <= '0;
							if (sp_q == 0) begin
								if (ncnt_q == 0) err = 1'b1;
								else begin
									phase_q <= PH_LEN; lbl_q <= 3'd4;
									cleft_q <= 4'd8; rem_q <= '0;
								end
							end else begin
								sp_q <= sp_q - 1'b1; st_q <= S_POPW; cleft_q <= '0;
							end
						end else begin
							cshift_q <= csh_n; cleft_q <= cleft_q - 1'b1;
						end
					end else begin
						if (nc_full) err = 1'b1;
						else if (bit_w) begin cleft_q <= 4'd8; cshift_q <= '0; end
						else if (sp_q >= SPW'(STACK_DEPTH)) err = 1'b1;
						else begin sp_q <= sp_q + 1'b1; ncnt_q <= ncnt_q + 1'b1; end
					end
					if (phase_q != PH_DEC) begin
						if (err) begin
							pend_q <= '{symbol: 8'd0, last: 1'b1, status: 1'b1};
							st_q <= S_OUT; done_q <= 1'b1;
						end else if (fin) begin
							// zero count: no beat leaves
							pend_q <= '0;
							done_q <= 1'b1; st_q <= S_OUT;
						end else if (!(leaf_now && sp_q != 0)) begin
							bitn_q <= bitn_q - 1'b1;
							st_q <= (bitn_q == 4'd1) ? S_LOAD : S_BIT;
						end
					end
				end
				S_POPW: begin
					bitn_q <= bitn_q - 1'b1;
					st_q <= (bitn_q == 4'd1) ? S_LOAD : S_BIT;
				end
				S_RD1: begin
					next_q <= bit_w ? nrd[8:0] : walk_q + 1'b1;
					st_q <= S_RD2;
				end
				S_RD2: begin
					bitn_q <= bitn_q - 1'b1;
					if (nrd[LEAF_BIT]) begin
						rem_q <= rem_q - 1'b1; walk_q <= '0;
						pend_q <= '{symbol: nrd[7:0], last: (rem_q == 32'd1), status: 1'b0};
						done_q <= (rem_q == 32'd1);
						st_q <= S_OUT;
					end else begin
						walk_q <= next_q;
						st_q <= (bitn_q == 4'd1) ? S_LOAD : S_BIT;
					end
				end
				S_OUT: begin
					// hold until the result register is free
					if (!rv_q || out_ch.ready) begin
						res_q <= pend_q;
						rv_q <= !(done_q && !pend_q.last && !pend_q.status);
						if (done_q) begin
							phase_q <= PH_TRIE; ncnt_q <= '0; sp_q <= '0; cshift_q <= '0;
							cleft_q <= '0; rem_q <= '0; lbl_q <= 3'd4; walk_q <= '0;
							done_q <= 1'b0; st_q <= S_LOAD;
						end else st_q <= (bitn_q == 4'd0) ? S_LOAD : S_BIT;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end

	a_pop_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> st_q == S_BIT) else $error("load did not start a byte");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && !out_ch.ready) |=> rv_q) else $error("result dropped");
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH)) else $error("stack pointer out of range");
endmodule
`default_nettype wire

### src/huffman_stream_decoder.sv
// ----------------------------------------------------------------------------
// huffman_stream_decoder: Huffman decoder over a preorder-serialised trie
// Rebuilds the trie, reads a 32-bit count, then emits decoded symbol beats.
// ----------------------------------------------------------------------------
// Each byte beat carries eight stream bits, taken MSB first. A two-deep
// queue holds incoming beats while the bit engine works. A byte is loaded
// in S_LOAD. Trie and count bits are taken in S_BIT, plus an S_POPW step
// per leaf that closes a pending right child (stack read). A code bit
// passes S_BIT, S_RD1 and S_RD2 (two node-table reads and the branch step),
// and each emitted symbol adds an S_OUT step, which waits for the result
// register while the receiver stalls.
// A malformed trie or overflow gives one beat with status 1 and last 1,
// and the next byte starts a new stream. No clearing pass after reset.
`default_nettype none
module huffman_stream_decoder #(
	parameter int MAX_NODES   = 512,
	parameter int STACK_DEPTH = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	hsd_byte_if.sink  in_ch,
	hsd_res_if.source out_ch
);
	import hsd_pkg::*;
	logic avail, pop;
	logic [7:0] head;

	hsd_front #(.DEPTH(2)) u_front (
		.clk, .arst_n, .in_ch, .avail, .head, .pop);
	hsd_back #(.MAX_NODES(MAX_NODES), .STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk, .arst_n, .avail, .head, .pop, .out_ch);
endmodule
`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the Huffman stream decoder
// Builds compressed streams bit by bit (preorder trie, 32-bit count, code
// words), sends them as byte beats, predicts every result beat with an own
// shadow of the decoder and checks the beats in order under random idling.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import hsd_pkg::*;

	localparam int NODES  = 512;
	localparam int STACKD = 256;

	logic clk;
	logic arst_n;

	hsd_byte_if in_ch ();
	hsd_res_if  out_ch ();

	huffman_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// idling knobs, in percent
	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;

	int unsigned bytes_sent;
	int unsigned beats_checked;
	int unsigned error_count;
	int unsigned streams_built;

	result_t expected_beats[$];

	// ------------------------------------------------------------------
	// Shadow decoder state
	// ------------------------------------------------------------------
	logic [1:0]  sh_phase;
	logic [9:0]  sh_nodes [NODES];
	logic [8:0]  sh_stack [STACKD];
	int unsigned sh_ncount;
	int unsigned sh_sp;
	logic [7:0]  sh_shift;
	int unsigned sh_bits_left;
	logic [31:0] sh_remaining;
	int unsigned sh_len_left;
	logic [8:0]  sh_walk;

	task automatic restart_shadow();
		sh_phase     = PH_TRIE;
		sh_ncount    = 0;
		sh_sp        = 0;
		sh_shift     = '0;
		sh_bits_left = 0;
		sh_remaining = '0;
		sh_len_left  = 4;
		sh_walk      = '0;
	endtask

	task automatic add_expected(logic [7:0] sym, logic lst, logic st);
		result_t r;
		r.symbol = sym;
		r.last   = lst;
		r.status = st;
		expected_beats.push_back(r);
	endtask

	// Advance the shadow over one accepted byte, queueing the beats it causes.
	task automatic decode_byte(logic [7:0] by);
		logic       b;
		logic       fail;
		logic       done;
		logic [9:0] e;
		logic [9:0] ne;
		logic [8:0] nxt;
		for (int i = 7; i >= 0; i--) begin
			b    = by[i];
			fail = 1'b0;
			done = 1'b0;
			if (sh_phase == PH_LEN) begin
				sh_shift = {sh_shift[6:0], b};
				sh_bits_left--;
				if (sh_bits_left == 0) begin
					sh_remaining = {sh_remaining[23:0], sh_shift};
					sh_shift     = '0;
					sh_len_left--;
					if (sh_len_left == 0) begin
						if (sh_remaining == 0) done = 1'b1;
						else begin
							sh_phase = PH_DEC;
							sh_walk  = '0;
						end
					end else sh_bits_left = 8;
				end
			end else if (sh_phase == PH_DEC) begin
				e   = sh_nodes[sh_walk];
				nxt = b ? e[8:0] : sh_walk + 9'd1;
				ne  = sh_nodes[nxt];
				if (ne[LEAF_BIT]) begin
					sh_remaining--;
					sh_walk = '0;
					if (sh_remaining == 0) begin
						add_expected(ne[7:0], 1'b1, 1'b0);
						done = 1'b1;
					end else add_expected(ne[7:0], 1'b0, 1'b0);
				end else sh_walk = nxt;
			end else if (sh_bits_left != 0) begin
				// collecting the symbol of a leaf
				sh_shift = {sh_shift[6:0], b};
				sh_bits_left--;
				if (sh_bits_left == 0) begin
					if (sh_ncount < NODES) sh_nodes[sh_ncount] = {1'b1, 1'b0, sh_shift};
					sh_ncount++;
					sh_shift = '0;
					if (sh_sp == 0) begin
						if (sh_ncount == 1) fail = 1'b1;
						else begin
							sh_phase     = PH_LEN;
							sh_len_left  = 4;
							sh_bits_left = 8;
							sh_remaining = '0;
						end
					end else begin
						sh_sp--;
						sh_nodes[sh_stack[sh_sp]] = {1'b0, sh_ncount[8:0]};
					end
				end
			end else begin
				// structure bit of a new node
				if (sh_ncount >= NODES) fail = 1'b1;
				else if (b) begin
					sh_bits_left = 8;
					sh_shift     = '0;
				end else if (sh_sp >= STACKD) fail = 1'b1;
				else begin
					sh_nodes[sh_ncount] = '0;
					sh_stack[sh_sp]     = sh_ncount[8:0];
					sh_sp++;
					sh_ncount++;
				end
			end
			if (fail) begin
				add_expected(8'h00, 1'b1, 1'b1);
				done = 1'b1;
			end
			if (done) begin
				restart_shadow();
				break;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Byte sender: called just after a rising edge or at the start
	// ------------------------------------------------------------------
	task automatic send_byte(logic [7:0] by);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= by;
		do @(posedge clk); while (!in_ch.ready);
		decode_byte(by);
		bytes_sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// Hold the sender until every queued beat has come out.
	task automatic drain();
		drop_valid();
		while (expected_beats.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result checker and receiver stalls
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		error_count++;
	endtask

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.ready <= 1'b0;
		else out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_beats.size() == 0)
				report_mismatch($sformatf("unexpected beat sym %02h last %0b status %0b",
					out_ch.symbol, out_ch.last, out_ch.status));
			else begin
				want = expected_beats.pop_front();
				beats_checked++;
				if (out_ch.symbol !== want.symbol)
					report_mismatch($sformatf("symbol %02h, want %02h",
						out_ch.symbol, want.symbol));
				if (out_ch.last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", out_ch.last, want.last));
				if (out_ch.status !== want.status)
					report_mismatch($sformatf("status %0b, want %0b",
						out_ch.status, want.status));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stream builder: bits are gathered here, then packed MSB first
	// ------------------------------------------------------------------
	logic        stream_bits[$];
	logic        tree_leaf [NODES];
	int unsigned tree_right[NODES];
	int unsigned tree_size;

	task automatic push_field(logic [31:0] v, int n);
		for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
	endtask

	function automatic logic [7:0] pick_symbol();
		case ($urandom_range(5))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// Emit a random full subtree with the given number of leaves, preorder.
	task automatic add_subtree(int unsigned leaves);
		int unsigned me;
		int unsigned split;
		me = tree_size;
		tree_size++;
		if (leaves == 1) begin
			tree_leaf[me] = 1'b1;
			stream_bits.push_back(1'b1);
			push_field(32'(pick_symbol()), 8);
		end else begin
			tree_leaf[me] = 1'b0;
			stream_bits.push_back(1'b0);
			split = $urandom_range(leaves - 1, 1);
			add_subtree(split);
			tree_right[me] = tree_size;
			add_subtree(leaves - split);
		end
	endtask

	// Pad the last byte with random bits (dropped by the block) and send.
	task automatic send_stream();
		logic [7:0] by;
		while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom));
		while (stream_bits.size() != 0) begin
			for (int i = 7; i >= 0; i--) by[i] = stream_bits.pop_front();
			send_byte(by);
		end
		streams_built++;
	endtask

	task automatic send_good_stream(int unsigned leaves, int unsigned count);
		int unsigned n;
		logic        b;
		tree_size = 0;
		add_subtree(leaves);
		push_field(count, 32);
		repeat (count) begin
			n = 0;
			while (!tree_leaf[n]) begin
				b = 1'($urandom);
				stream_bits.push_back(b);
				n = b ? tree_right[n] : n + 1;
			end
		end
		send_stream();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_extreme_symbols();
		// two leaves holding the field extremes, then three code words using both
		stream_bits.push_back(1'b0);
		stream_bits.push_back(1'b1);
		push_field(32'h00, 8);
		stream_bits.push_back(1'b1);
		push_field(32'hff, 8);
		push_field(32'd3, 32);
		stream_bits.push_back(1'b0);
		stream_bits.push_back(1'b1);
		stream_bits.push_back(1'b1);
		send_stream();
		send_good_stream(5, 8);
	endtask

	task automatic test_zero_count();
		tree_size = 0;
		add_subtree(3);
		push_field(32'd0, 32);
		send_stream();
		send_good_stream(2, 1);
	endtask

	task automatic test_single_leaf();
		stream_bits.push_back(1'b1);
		push_field(32'(pick_symbol()), 8);
		send_stream();
		send_good_stream(3, 2);
	endtask

	task automatic test_stack_overflow();
		// one internal node more than the stack can hold
		repeat (STACKD + 1) stream_bits.push_back(1'b0);
		send_stream();
		send_good_stream(4, 3);
	endtask

	task automatic test_node_overflow();
		// keep one right child pending while the table fills up
		stream_bits.push_back(1'b0);
		repeat (NODES / 2 - 1) begin
			stream_bits.push_back(1'b0);
			stream_bits.push_back(1'b1);
			push_field(32'(pick_symbol()), 8);
		end
		stream_bits.push_back(1'b0);
		stream_bits.push_back(1'b0);
		send_stream();
		send_good_stream(2, 2);
	endtask

	task automatic test_pause_until_empty();
		send_good_stream(6, 5);
		drain();
		send_good_stream(3, 4);
		drain();
	endtask

	// Mostly well-formed streams; the rest are broken ones or zero counts.
	task automatic test_random_streams(int unsigned idle, int unsigned stall, int unsigned quota);
		int unsigned first;
		src_idle_pct  = idle;
		snk_stall_pct = stall;
		first = bytes_sent;
		while (bytes_sent - first < quota) begin
			case ($urandom_range(9))
				0: begin
					stream_bits.push_back(1'b1);
					push_field(32'(pick_symbol()), 8);
					send_stream();
				end
				1: begin
					tree_size = 0;
					add_subtree($urandom_range(8, 2));
					push_field(32'd0, 32);
					send_stream();
				end
				2:       send_good_stream($urandom_range(40, 2), $urandom_range(8, 1));
				default: send_good_stream($urandom_range(10, 2), $urandom_range(8, 1));
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.data_byte = '0;
		src_idle_pct    = 0;
		snk_stall_pct   = 0;
		bytes_sent      = 0;
		beats_checked   = 0;
		error_count     = 0;
		streams_built   = 0;
		restart_shadow();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_extreme_symbols();
		test_zero_count();
		test_single_leaf();
		test_stack_overflow();
		test_node_overflow();
		test_pause_until_empty();

		test_random_streams(0, 0, 40);
		test_random_streams(88, 0, 40);
		test_random_streams(0, 88, 40);
		test_random_streams(33, 33, 40);

		drop_valid();
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("Covered %0d streams in %0d bytes, %0d result beats checked,",
			streams_built, bytes_sent, beats_checked);
		$display("including overflow, single-leaf and zero-count streams under idling.");
		if (error_count == 0 && expected_beats.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	initial begin
		#(8 * 1000000);
		$display("TIMEOUT with %0d beats outstanding", expected_beats.size());
		$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
src/hsd_pkg.sv
src/hsd_if.sv
src/hsd_ram.sv
src/hsd_front.sv
src/hsd_back.sv
src/huffman_stream_decoder.sv
sim/tb_top.sv
